>>> rtl/core/coefficient_rejection_sampler_assert.svh
// assertion macros for the coefficient rejection sampler
// expects clk and rst_n in the scope where a macro is used
`ifndef COEFFICIENT_REJECTION_SAMPLER_ASSERT_SVH
`define COEFFICIENT_REJECTION_SAMPLER_ASSERT_SVH

// condition that holds at every clock edge out of reset
`define CRS_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// condition that implies another at the same edge
`define CRS_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

>>> rtl/core/crs_pkg.sv
// shared types, constants and helpers for the coefficient rejection sampler
// no dependencies
`default_nettype none

package crs_pkg;

    localparam int unsigned CNT_W      = 9;
    localparam int unsigned IDX_W      = 8;
    localparam int unsigned COEF_W     = 23;
    localparam int unsigned VAL_W      = 20;
    localparam int unsigned MOD_W      = 22;
    localparam int unsigned GAMMA_W    = 19;
    localparam int unsigned CFG_DATA_W = 22;
    localparam int unsigned CFG_IDX_W  = 4;
    localparam int unsigned QDEPTH     = 4;

    localparam logic              MODE_WIDE        = 1'b1;
    localparam logic [3:0]        NIB_REJECT       = 4'hF;
    localparam logic [2:0]        GROUP_FULL       = 3'd4;
    localparam logic [MOD_W-1:0]  MODULUS_RESET    = 22'd4194303;
    localparam logic [GAMMA_W-1:0] RANGE_HALF_RESET = 19'd262144;
    localparam logic [CNT_W-1:0]  COEFF_COUNT_RESET = 9'd256;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SAMPLE_MODE = 4'd0,
        REG_MODULUS     = 4'd1,
        REG_RANGE_HALF  = 4'd2,
        REG_COEFF_COUNT = 4'd3
    } reg_index_t;

    typedef struct packed {
        logic               mode;
        logic [MOD_W-1:0]   modulus;
        logic [GAMMA_W-1:0] range_half;
        logic [CNT_W-1:0]   lim;
    } cfg_t;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic [IDX_W-1:0] index;
        logic             done;
    } slot_t;

    typedef struct packed {
        logic [1:0] emit;
        slot_t      slot1;
        slot_t      slot0;
    } entry_t;

    function automatic logic [2:0] mod5(input logic [3:0] v);
        logic [2:0] r;
        case (v)
            4'd0, 4'd5, 4'd10, 4'd15: r = 3'd0;
            4'd1, 4'd6, 4'd11:        r = 3'd1;
            4'd2, 4'd7, 4'd12:        r = 3'd2;
            4'd3, 4'd8, 4'd13:        r = 3'd3;
            4'd4, 4'd9, 4'd14:        r = 3'd4;
            default:                  r = 3'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/crs_front.sv
// front end: takes bytes, keeps the five-byte group and the coefficient count,
// classifies candidates and pushes them to the queue; uses crs_pkg
`default_nettype none

module crs_front (
    input  logic            clk,
    input  logic            rst_n,
    input  crs_pkg::cfg_t   cfg,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic [7:0]      data_byte,
    input  logic            new_poly,
    input  logic            realign,
    input  logic            q_full,
    output logic            q_push,
    output crs_pkg::entry_t q_entry
);
    import crs_pkg::*;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [31:0]      gbytes_reg, gbytes_next;
    logic [2:0]       gpos_reg, gpos_next;

    logic                accept;
    logic                clear;
    logic [CNT_W-1:0]    cnt_e, cnt1;
    logic [31:0]         gbytes_e;
    logic [2:0]          gpos_e;
    logic                active;
    logic                wide;
    logic                group_done;
    logic [VAL_W-1:0]    t0, t1;
    logic signed [21:0]  hi_lim, sub_val, v0, v1, r0, r1;
    logic                c0ok, c1ok, emit0, emit1;
    logic [VAL_W-1:0]    val0, val1;

    always_comb
    begin
        accept   = in_valid && !q_full;
        in_stall = q_full;
        clear    = new_poly || realign;
        cnt_e    = new_poly ? '0 : cnt_reg;
        gbytes_e = clear ? '0 : gbytes_reg;
        gpos_e   = clear ? '0 : gpos_reg;
        active   = cnt_e < cfg.lim;
        wide     = cfg.mode == MODE_WIDE;
        group_done = gpos_e == GROUP_FULL;

        t0 = gbytes_e[19:0];
        t1 = {data_byte, gbytes_e[31:20]};

        hi_lim  = $signed({1'b0, cfg.range_half, 2'b00}) - 22'sd3;
        sub_val = $signed({2'b00, cfg.range_half, 1'b0}) - 22'sd1;
        v0 = $signed({2'b00, t0});
        v1 = $signed({2'b00, t1});
        r0 = (v0 >= sub_val) ? v0 - sub_val : v0;
        r1 = (v1 >= sub_val) ? v1 - sub_val : v1;

        if (wide)
        begin
            c0ok = group_done && (v0 <= hi_lim);
            c1ok = group_done && (v1 <= hi_lim);
            val0 = r0[VAL_W-1:0];
            val1 = r1[VAL_W-1:0];
        end
        else
        begin
            c0ok = data_byte[3:0] != NIB_REJECT;
            c1ok = data_byte[7:4] != NIB_REJECT;
            val0 = VAL_W'(data_byte[3:0]);
            val1 = VAL_W'(data_byte[7:4]);
        end

        emit0 = active && c0ok;
        cnt1  = cnt_e + CNT_W'(emit0);
        emit1 = c1ok && (cnt1 < cfg.lim);

        q_entry.emit        = {emit1, emit0};
        q_entry.slot0.value = val0;
        q_entry.slot0.index = cnt_e[IDX_W-1:0];
        q_entry.slot0.done  = ({1'b0, cnt_e} + 10'd1) == {1'b0, cfg.lim};
        q_entry.slot1.value = val1;
        q_entry.slot1.index = cnt1[IDX_W-1:0];
        q_entry.slot1.done  = ({1'b0, cnt1} + 10'd1) == {1'b0, cfg.lim};
        q_push = accept && (emit0 || emit1);
    end

    always_comb
    begin
        cnt_next    = cnt_reg;
        gbytes_next = gbytes_reg;
        gpos_next   = gpos_reg;
        if (accept)
        begin
            cnt_next    = cnt1 + CNT_W'(emit1);
            gbytes_next = gbytes_e;
            gpos_next   = gpos_e;
            if (active && wide)
            begin
                if (group_done)
                begin
                    gbytes_next = '0;
                    gpos_next   = '0;
                end
                else
                begin
                    gbytes_next = gbytes_e | (32'(data_byte) << {gpos_e[1:0], 3'b000});
                    gpos_next   = gpos_e + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            gbytes_reg <= '0;
            gpos_reg   <= '0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            gbytes_reg <= gbytes_next;
            gpos_reg   <= gpos_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/crs_queue.sv
// short queue of classified entries between front and back end
// uses crs_pkg
`default_nettype none

module crs_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  crs_pkg::entry_t push_entry,
    input  logic            pop,
    output crs_pkg::entry_t head,
    output logic            not_empty,
    output logic            full,
    output logic [$clog2(crs_pkg::QDEPTH+1)-1:0] count
);
    import crs_pkg::*;

    localparam int unsigned PTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    entry_t             entry_reg [QDEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QDEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_comb
    begin
        head        = entry_reg[rd_ptr_reg];
        not_empty   = count_reg != '0;
        full        = count_reg == QCNT_W'(QDEPTH);
        count       = count_reg;
        wr_ptr_next = push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/crs_back.sv
// back end: takes queue entries one slot at a time, forms the coefficient
// and holds it in the output register; uses crs_pkg
`default_nettype none

module crs_back (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  crs_pkg::cfg_t                         cfg,
    input  logic                                  q_valid,
    input  crs_pkg::entry_t                       q_head,
    output logic                                  q_pop,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [crs_pkg::COEF_W-1:0]            coefficient,
    output logic [crs_pkg::IDX_W-1:0]             coeff_index,
    output logic                                  poly_done,
    output logic                                  last_of_item
);
    import crs_pkg::*;

    logic              slot_reg, slot_next;
    logic              valid_reg, valid_next;
    logic [COEF_W-1:0] coef_reg, coef_next;
    logic [IDX_W-1:0]  index_reg, index_next;
    logic              done_reg, done_next;
    logic              last_reg, last_next;

    logic              load;
    logic              use1;
    logic              last_now;
    slot_t             cur;

    always_comb
    begin
        load     = q_valid && (!valid_reg || !out_stall);
        use1     = slot_reg || !q_head.emit[0];
        last_now = use1 || !q_head.emit[1];
        cur      = use1 ? q_head.slot1 : q_head.slot0;
        q_pop    = load && last_now;

        if (cfg.mode == MODE_WIDE)
        begin
            coef_next = COEF_W'(cfg.modulus) + COEF_W'(cfg.range_half)
                      - COEF_W'(1) - COEF_W'(cur.value);
        end
        else
        begin
            coef_next = COEF_W'(cfg.modulus) - COEF_W'(2) + COEF_W'(mod5(cur.value[3:0]));
        end
        index_next = cur.index;
        done_next  = cur.done;
        last_next  = last_now;
        slot_next  = load ? !last_now : slot_reg;
        valid_next = load || (valid_reg && out_stall);
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            coef_reg  <= coef_next;
            index_reg <= index_next;
            done_reg  <= done_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            slot_reg  <= slot_next;
            valid_reg <= valid_next;
        end
    end

    assign out_valid    = valid_reg;
    assign coefficient  = coef_reg;
    assign coeff_index  = index_reg;
    assign poly_done    = done_reg;
    assign last_of_item = last_reg;

endmodule

`default_nettype wire

>>> rtl/core/coefficient_rejection_sampler.sv
// Coefficient rejection sampler. One byte is taken per clock while the four-entry
// queue between front and back end has room; a byte yields zero, one or two
// coefficients, and the output register sends one coefficient per cycle while
// out_stall is low. The first coefficient of a byte passes through the queue and
// then the output register before it appears. Nothing needs clearing after
// reset. Register writes are always accepted and are registered before they
// take effect.
// top level: config registers, front end, queue, back end; uses crs_pkg,
// crs_front, crs_queue, crs_back and coefficient_rejection_sampler_assert.svh
`default_nettype none

`include "coefficient_rejection_sampler_assert.svh"

module coefficient_rejection_sampler #(
    parameter int unsigned MAX_COEFFS = 256
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [crs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [crs_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [7:0]                        data_byte,
    input  logic                              new_poly,
    input  logic                              realign,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [crs_pkg::COEF_W-1:0]        coefficient,
    output logic [crs_pkg::IDX_W-1:0]         coeff_index,
    output logic                              poly_done,
    output logic                              last_of_item
);
    import crs_pkg::*;

    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    logic               mode_reg, mode_next;
    logic [MOD_W-1:0]   modulus_reg, modulus_next;
    logic [GAMMA_W-1:0] gamma_reg, gamma_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    cfg_t               cfg;
    logic               q_push, q_pop, q_valid, q_full;
    entry_t             q_entry, q_head;
    logic [QCNT_W-1:0]  q_count;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        mode_next    = mode_reg;
        modulus_next = modulus_reg;
        gamma_next   = gamma_reg;
        count_next   = count_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SAMPLE_MODE: mode_next    = cfg_data[0];
                REG_MODULUS:     modulus_next = cfg_data[MOD_W-1:0];
                REG_RANGE_HALF:  gamma_next   = cfg_data[GAMMA_W-1:0];
                REG_COEFF_COUNT: count_next   = cfg_data[CNT_W-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= 1'b0;
            modulus_reg <= MODULUS_RESET;
            gamma_reg   <= RANGE_HALF_RESET;
            count_reg   <= COEFF_COUNT_RESET;
        end
        else
        begin
            mode_reg    <= mode_next;
            modulus_reg <= modulus_next;
            gamma_reg   <= gamma_next;
            count_reg   <= count_next;
        end
    end

    always_comb
    begin
        cfg.mode       = mode_reg;
        cfg.modulus    = modulus_reg;
        cfg.range_half = gamma_reg;
        cfg.lim        = (32'(count_reg) > MAX_COEFFS) ? CNT_W'(MAX_COEFFS) : count_reg;
    end

    crs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .new_poly  (new_poly),
        .realign   (realign),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (q_entry)
    );

    crs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .head       (q_head),
        .not_empty  (q_valid),
        .full       (q_full),
        .count      (q_count)
    );

    crs_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .q_valid      (q_valid),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .coefficient  (coefficient),
        .coeff_index  (coeff_index),
        .poly_done    (poly_done),
        .last_of_item (last_of_item)
    );

    `CRS_ASSERT_ALWAYS(a_queue_bound, q_count <= QCNT_W'(QDEPTH), "queue count past depth")
    `CRS_ASSERT_IMPLY(a_done_is_last, out_valid && poly_done, last_of_item, "done not last")
    `CRS_ASSERT_IMPLY(a_no_push_full, q_push, !q_full, "push into full queue")

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
// testbench for coefficient_rejection_sampler: a directed table, then random phases of bytes
// under changing register settings; every coefficient is checked against an in-bench model,
// or against the directed table's expected values; depends on crs_pkg and the sampler rtl
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import crs_pkg::*;

    localparam int unsigned MAX_COEFFS = 256;
    localparam int unsigned SETTLE     = 20;
    localparam int unsigned N_PHASES   = 12;
    localparam int unsigned PHASE_LEN  = 34;

    typedef struct packed {
        logic [COEF_W-1:0] coef;
        logic [IDX_W-1:0]  idx;
        logic              done;
        logic              last;
    } coeff_rec_t;

    typedef struct packed {
        logic                  wr;
        reg_index_t            reg_sel;
        logic [CFG_DATA_W-1:0] value;
        logic [7:0]            b;
        logic                  np;
        logic                  ra;
        logic                  known;
        logic [1:0]            n_known;
        logic [COEF_W-1:0]     c0;
        logic [COEF_W-1:0]     c1;
    } step_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic [7:0]            data_byte;
    logic                  new_poly;
    logic                  realign;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [COEF_W-1:0]     coefficient;
    logic [IDX_W-1:0]      coeff_index;
    logic                  poly_done;
    logic                  last_of_item;

    // sampler model state
    logic               cur_mode;
    logic [MOD_W-1:0]   cur_modulus;
    logic [GAMMA_W-1:0] cur_range_half;
    logic [CNT_W-1:0]   cur_coeff_count;
    logic [CNT_W-1:0]   produced = '0;
    logic [31:0]        grp = '0;
    logic [2:0]         grp_pos = '0;
    coeff_rec_t         fresh [2];
    int                 n_fresh = 0;

    coeff_rec_t  coeffs_due [$];
    step_t       cur_row;
    int unsigned send_gap_pct;
    int unsigned stall_pct;
    int unsigned mismatches = 0;

    step_t dir_steps [32] = '{
        '{1'b0, REG_SAMPLE_MODE, 22'd0, 8'h00, 1'b1, 1'b0, 1'b1, 2'd2, 23'd4194301, 23'd4194301},
        '{1'b0, REG_SAMPLE_MODE, 22'd0, 8'hFF, 1'b0, 1'b0, 1'b1, 2'd0, 23'd0, 23'd0},
        '{1'b0, REG_SAMPLE_MODE, 22'd0, 8'hF4, 1'b0, 1'b0, 1'b1, 2'd1, 23'd4194305, 23'd0},
        '{1'b0, REG_SAMPLE_MODE, 22'd0, 8'h9E, 1'b0, 1'b0, 1'b1, 2'd2, 23'd4194305, 23'd4194305},
        '{1'b0, REG_SAMPLE_MODE, 22'd0, 8'h5A, 1'b0, 1'b1, 1'b1, 2'd2, 23'd4194301, 23'd4194301},
        '{1'b0, REG_SAMPLE_MODE, 22'd0, 8'h3C, 1'b0, 1'b0, 1'b1, 2'd2, 23'd4194303, 23'd4194304},
        '{1'b0, REG_SAMPLE_MODE, 22'd0, 8'h71, 1'b0, 1'b0, 1'b1, 2'd2, 23'd4194302, 23'd4194303},
        '{1'b0, REG_SAMPLE_MODE, 22'd0, 8'h86, 1'b0, 1'b0, 1'b1, 2'd2, 23'd4194302, 23'd4194304},
        '{1'b0, REG_SAMPLE_MODE, 22'd0, 8'hBD, 1'b0, 1'b0, 1'b1, 2'd2, 23'd4194304, 23'd4194302},
        '{1'b0, REG_SAMPLE_MODE, 22'd0, 8'h2F, 1'b0, 1'b0, 1'b1, 2'd1, 23'd4194303, 23'd0},
        '{1'b1, REG_MODULUS, 22'd1, 8'h00, 1'b0, 1'b0, 1'b0, 2'd0, 23'd0, 23'd0},
        '{1'b1, REG_COEFF_COUNT, 22'd3, 8'h00, 1'b0, 1'b0, 1'b0, 2'd0, 23'd0, 23'd0},
        '{1'b0, REG_SAMPLE_MODE, 22'd0, 8'h10, 1'b1, 1'b0, 1'b1, 2'd2, 23'd8388607, 23'd0},
        '{1'b0, REG_SAMPLE_MODE, 22'd0, 8'h32, 1'b0, 1'b0, 1'b1, 2'd1, 23'd1, 23'd0},
        '{1'b0, REG_SAMPLE_MODE, 22'd0, 8'h44, 1'b0, 1'b0, 1'b1, 2'd0, 23'd0, 23'd0},
        '{1'b0, REG_SAMPLE_MODE, 22'd0, 8'h00, 1'b1, 1'b0, 1'b1, 2'd2, 23'd8388607, 23'd8388607},
        '{1'b1, REG_COEFF_COUNT, 22'd0, 8'h00, 1'b0, 1'b0, 1'b0, 2'd0, 23'd0, 23'd0},
        '{1'b0, REG_SAMPLE_MODE, 22'd0, 8'h66, 1'b1, 1'b0, 1'b1, 2'd0, 23'd0, 23'd0},
        '{1'b1, REG_SAMPLE_MODE, 22'd1, 8'h00, 1'b0, 1'b0, 1'b0, 2'd0, 23'd0, 23'd0},
        '{1'b1, REG_MODULUS, 22'd4194303, 8'h00, 1'b0, 1'b0, 1'b0, 2'd0, 23'd0, 23'd0},
        '{1'b1, REG_RANGE_HALF, 22'd262144, 8'h00, 1'b0, 1'b0, 1'b0, 2'd0, 23'd0, 23'd0},
        '{1'b1, REG_COEFF_COUNT, 22'd256, 8'h00, 1'b0, 1'b0, 1'b0, 2'd0, 23'd0, 23'd0},
        '{1'b0, REG_SAMPLE_MODE, 22'd0, 8'h00, 1'b1, 1'b0, 1'b1, 2'd0, 23'd0, 23'd0},
        '{1'b0, REG_SAMPLE_MODE, 22'd0, 8'h00, 1'b0, 1'b0, 1'b1, 2'd0, 23'd0, 23'd0},
        '{1'b0, REG_SAMPLE_MODE, 22'd0, 8'h00, 1'b0, 1'b0, 1'b1, 2'd0, 23'd0, 23'd0},
        '{1'b0, REG_SAMPLE_MODE, 22'd0, 8'h00, 1'b0, 1'b0, 1'b1, 2'd0, 23'd0, 23'd0},
        '{1'b0, REG_SAMPLE_MODE, 22'd0, 8'h00, 1'b0, 1'b0, 1'b1, 2'd2, 23'd4456446, 23'd4456446},
        '{1'b0, REG_SAMPLE_MODE, 22'd0, 8'hFF, 1'b0, 1'b0, 1'b1, 2'd0, 23'd0, 23'd0},
        '{1'b0, REG_SAMPLE_MODE, 22'd0, 8'hFF, 1'b0, 1'b0, 1'b1, 2'd0, 23'd0, 23'd0},
        '{1'b0, REG_SAMPLE_MODE, 22'd0, 8'hFF, 1'b0, 1'b0, 1'b1, 2'd0, 23'd0, 23'd0},
        '{1'b0, REG_SAMPLE_MODE, 22'd0, 8'hFF, 1'b0, 1'b0, 1'b1, 2'd0, 23'd0, 23'd0},
        '{1'b0, REG_SAMPLE_MODE, 22'd0, 8'hFF, 1'b0, 1'b0, 1'b1, 2'd0, 23'd0, 23'd0}
    };

    coefficient_rejection_sampler #(.MAX_COEFFS(MAX_COEFFS)) DUT (.*);

    function automatic logic [CNT_W-1:0] poly_limit();
        if (cur_coeff_count > MAX_COEFFS)
            return CNT_W'(MAX_COEFFS);
        return cur_coeff_count;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] d);
        case (idx)
            REG_SAMPLE_MODE: cur_mode        = d[0];
            REG_MODULUS:     cur_modulus     = d[MOD_W-1:0];
            REG_RANGE_HALF:  cur_range_half  = d[GAMMA_W-1:0];
            REG_COEFF_COUNT: cur_coeff_count = d[CNT_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic void add_coef(input logic [COEF_W-1:0] c);
        fresh[n_fresh].coef = c;
        fresh[n_fresh].idx  = produced[IDX_W-1:0];
        fresh[n_fresh].done = (({1'b0, produced} + 1'b1) == {1'b0, poly_limit()});
        fresh[n_fresh].last = 1'b0;
        produced = produced + 1'b1;
        n_fresh++;
    endfunction

    function automatic bit wide_coef(input logic [VAL_W-1:0] t, output logic [COEF_W-1:0] c);
        longint g;
        longint v;
        longint m;
        g = longint'(cur_range_half);
        v = longint'(t);
        m = longint'(cur_modulus);
        c = '0;
        if (v > 4 * g - 3)
            return 1'b0;
        if (v >= 2 * g - 1)
            v = v - (2 * g - 1);
        c = COEF_W'(m + g - 1 - v);
        return 1'b1;
    endfunction

    function automatic void sample_byte(input logic [7:0] b, input logic np, input logic ra);
        logic [31:0]       s;
        logic [COEF_W-1:0] c;
        logic [3:0]        nib [2];
        n_fresh = 0;
        if (np)
        begin
            produced = '0;
            grp      = '0;
            grp_pos  = '0;
        end
        if (ra)
        begin
            grp     = '0;
            grp_pos = '0;
        end
        if (produced >= poly_limit())
            return;
        if (cur_mode != MODE_WIDE)
        begin
            nib[0] = b[3:0];
            nib[1] = b[7:4];
            for (int k = 0; k < 2; k++)
            begin
                if (nib[k] != NIB_REJECT && produced < poly_limit())
                begin
                    s = 32'(cur_modulus) - 32'd2 + 32'(nib[k] % 4'd5);
                    add_coef(s[COEF_W-1:0]);
                end
            end
        end
        else if (grp_pos < GROUP_FULL)
        begin
            grp     = grp | (32'(b) << (8 * grp_pos));
            grp_pos = grp_pos + 3'd1;
        end
        else
        begin
            if (wide_coef(grp[VAL_W-1:0], c))
                add_coef(c);
            if (produced < poly_limit() && wide_coef({b, grp[31:20]}, c))
                add_coef(c);
            grp     = '0;
            grp_pos = '0;
        end
        if (n_fresh > 0)
            fresh[n_fresh-1].last = 1'b1;
    endfunction

    task automatic push_byte(input logic [7:0] b, input logic np, input logic ra);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        new_poly  <= np;
        realign   <= ra;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        apply_reg(idx, d);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        for (int i = 0; i < 20000 && coeffs_due.size() != 0; i++)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    always @(posedge clk)
    begin : watch
        coeff_rec_t got;
        coeff_rec_t want;
        if (rst_n && in_valid && !in_stall)
        begin
            sample_byte(data_byte, new_poly, realign);
            if (cur_row.known)
            begin
                n_fresh       = cur_row.n_known;
                fresh[0].coef = cur_row.c0;
                fresh[1].coef = cur_row.c1;
            end
            for (int k = 0; k < n_fresh; k++)
                coeffs_due.push_back(fresh[k]);
        end
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{coefficient, coeff_index, poly_done, last_of_item};
            if (coeffs_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected coefficient %0d index %0d", coefficient, coeff_index);
            end
            else
            begin
                want = coeffs_due.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch exp/got: coef %0d/%0d index %0d/%0d",
                                  " done %b/%b last %b/%b"},
                                 want.coef, got.coef, want.idx, got.idx,
                                 want.done, got.done, want.last, got.last);
                end
            end
        end
    end

    initial
    begin : stimulus
        logic [CFG_DATA_W-1:0] d;
        logic [7:0]            b;
        logic                  np;
        logic                  ra;
        int                    taken;
        cfg_valid       = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        in_valid        = 1'b0;
        data_byte       = '0;
        new_poly        = 1'b0;
        realign         = 1'b0;
        rst_n           = 1'b0;
        cur_mode        = 1'b0;
        cur_modulus     = MODULUS_RESET;
        cur_range_half  = RANGE_HALF_RESET;
        cur_coeff_count = COEFF_COUNT_RESET;
        cur_row         = '0;
        send_gap_pct    = 25;
        stall_pct       = 57;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_steps[i])
        begin
            cur_row = dir_steps[i];
            if (cur_row.wr)
            begin
                drain();
                write_reg(cur_row.reg_sel, cur_row.value);
            end
            else
                push_byte(cur_row.b, cur_row.np, cur_row.ra);
        end
        cur_row = '0;

        for (int p = 0; p < N_PHASES; p++)
        begin
            send_gap_pct = (p < 4) ? 25 : (p < 8) ? 57 : 0;
            stall_pct    = (p < 4) ? 57 : (p < 8) ? 25 : 0;
            drain();
            if ($urandom_range(2) != 0)
                write_reg(REG_SAMPLE_MODE, 22'($urandom));
            if ($urandom_range(2) != 0)
            begin
                case ($urandom_range(3))
                    0:       d = 22'd1;
                    1:       d = MODULUS_RESET;
                    2:       d = 22'd2;
                    default: d = 22'($urandom);
                endcase
                write_reg(REG_MODULUS, d);
            end
            if ($urandom_range(2) != 0)
            begin
                d = 22'($urandom);
                case ($urandom_range(5))
                    0:       d[GAMMA_W-1:0] = '0;
                    1:       d[GAMMA_W-1:0] = 19'd1;
                    2:       d[GAMMA_W-1:0] = RANGE_HALF_RESET;
                    3:       d[GAMMA_W-1:0] = '1;
                    4:       d[GAMMA_W-1:0] = 19'($urandom_range(64, 1));
                    default: ;
                endcase
                write_reg(REG_RANGE_HALF, d);
            end
            if ($urandom_range(2) != 0)
            begin
                d = 22'($urandom);
                case ($urandom_range(7))
                    0:       d[CNT_W-1:0] = '0;
                    1:       d[CNT_W-1:0] = 9'd1;
                    2:       d[CNT_W-1:0] = COEFF_COUNT_RESET;
                    3:       d[CNT_W-1:0] = '1;
                    4, 5:    d[CNT_W-1:0] = 9'($urandom_range(40, 1));
                    default: ;
                endcase
                write_reg(REG_COEFF_COUNT, d);
            end
            if ($urandom_range(3) == 0)
                write_reg(CFG_IDX_W'($urandom_range(15, int'(REG_COEFF_COUNT) + 1)),
                          22'($urandom));

            taken = 0;
            while (taken < PHASE_LEN)
            begin
                if (produced >= poly_limit())
                    np = ($urandom_range(9) < 4);
                else
                    np = ($urandom_range(99) < 3);
                ra = ($urandom_range(19) == 0);
                case ($urandom_range(7))
                    0:       b = 8'h00;
                    1:       b = 8'hFF;
                    default: b = 8'($urandom);
                endcase
                if (np || produced < poly_limit() || poly_limit() == 0)
                    taken++;
                push_byte(b, np, ra);
            end
        end

        drain();
        if (mismatches == 0 && coeffs_due.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin : watchdog
        #1_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
